// ----- design/pafb_pkg.sv -----
`default_nettype none

package pafb_pkg;

  // Fixed field widths
  localparam int CMD_W        = 1;
  localparam int CH_FIELD_W   = 3;
  localparam int SAMPLE_W     = 24;
  localparam int COEF_IDX_W   = 9;
  localparam int COEF_W       = 18;
  localparam int SUB_W        = 32;
  localparam int BAND_FIELD_W = 5;

  // Fixed-point constants
  localparam int COS_W   = 18;
  localparam int FRAC_SH = 16;
  localparam int COS_PTS = 65;
  localparam longint COS_C1 = 64'sd1073418433;

  // Request kinds
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_COEF   = 1'b1;

  // Parameter defaults
  localparam int DEF_CHANNELS = 6;
  localparam int DEF_BANDS    = 32;
  localparam int DEF_TAPS     = 8;

  typedef logic [COS_PTS-1:0][COS_W-1:0] cos_rom_t;

  // Tags that travel with one operand pair through the MAC
  typedef struct packed {
    logic valid;
    logic neg;
    logic first;
    logic last;
  } mac_ctl_t;

  // Quarter-wave cosine table, cos(j*pi/128) in Q1.16, by integer recurrence
  function automatic cos_rom_t build_cos_rom();
    longint   c [COS_PTS];
    cos_rom_t r;
    int       j;
    c[0] = 64'sd1 <<< 30;
    c[1] = COS_C1;
    for (j = 1; j < COS_PTS - 1; j++) begin
      c[j + 1] = ((2 * COS_C1 * c[j] + (64'sd1 <<< 29)) >>> 30) - c[j - 1];
    end
    for (j = 0; j < COS_PTS - 1; j++) begin
      r[j] = COS_W'((c[j] + (64'sd1 <<< 13)) >>> 14);
    end
    r[COS_PTS - 1] = '0;
    return r;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

  // Full-wave cosine of a*pi/128
  function automatic logic signed [COS_W-1:0] cos_lookup(input logic [7:0] a);
    logic signed [COS_W-1:0] r;
    if (a <= 8'd64) begin
      r = $signed(COS_ROM[7'(a)]);
    end else if (a <= 8'd128) begin
      r = -$signed(COS_ROM[7'(8'd128 - a)]);
    end else if (a <= 8'd192) begin
      r = -$signed(COS_ROM[7'(a - 8'd128)]);
    end else begin
      r = $signed(COS_ROM[7'(9'd256 - {1'b0, a})]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/pafb_ifs.sv -----
`default_nettype none

// Input request channel
interface pafb_in_if;
  logic                                    valid;
  logic                                    ready;
  logic [pafb_pkg::CMD_W-1:0]              cmd;
  logic [pafb_pkg::CH_FIELD_W-1:0]         channel;
  logic signed [pafb_pkg::SAMPLE_W-1:0]    sample;
  logic [pafb_pkg::COEF_IDX_W-1:0]         coef_index;
  logic signed [pafb_pkg::COEF_W-1:0]      coef_value;

  modport source (output valid, cmd, channel, sample, coef_index, coef_value, input ready);
  modport sink   (input valid, cmd, channel, sample, coef_index, coef_value, output ready);
endinterface

// Subband result channel
interface pafb_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [pafb_pkg::SUB_W-1:0]       subband_value;
  logic [pafb_pkg::BAND_FIELD_W-1:0]       band_index;
  logic [pafb_pkg::CH_FIELD_W-1:0]         channel_out;
  logic                                    last;
  logic                                    saturated;

  modport source (output valid, subband_value, band_index, channel_out, last, saturated,
                  input ready);
  modport sink   (input valid, subband_value, band_index, channel_out, last, saturated,
                  output ready);
endinterface

`default_nettype wire

// ----- design/pafb_mac.sv -----
`default_nettype none

// Shared multiply-accumulate: operand register, product register, accumulator.
module pafb_mac #(
  parameter int A_W   = 29,
  parameter int B_W   = 18,
  parameter int ACC_W = 53
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire pafb_pkg::mac_ctl_t       ctl,
  input  wire logic signed [A_W-1:0]    op_a,
  input  wire logic signed [B_W-1:0]    op_b,
  output logic signed [ACC_W-1:0]       acc,
  output logic                          done
);

  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (pafb_pkg::FRAC_SH - 1);

  pafb_pkg::mac_ctl_t          ctl1_r, ctl2_r;
  logic signed [A_W-1:0]       a1_r;
  logic signed [B_W-1:0]       b1_r;
  logic signed [A_W+B_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]     acc_r;
  logic                        done_r;

  // control tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      done_r <= 1'b0;
    end else begin
      ctl1_r <= ctl;
      ctl2_r <= ctl1_r;
      done_r <= ctl2_r.valid && ctl2_r.last;
    end
  end

  // datapath: sign applied on the way in, rounding bias on the first term
  always_ff @(posedge clk) begin
    a1_r   <= ctl.neg ? -op_a : op_a;
    b1_r   <= op_b;
    prod_r <= a1_r * b1_r;
    if (ctl2_r.valid) begin
      if (ctl2_r.first) begin
        acc_r <= ACC_W'(prod_r) + RND;
      end else begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

`default_nettype wire

// ----- design/polyphase_analysis_filterbank_core.sv -----
`default_nettype none
// Sample requests that do not complete a block and coefficient writes are taken while idle.
// Every BANDS-th sample of a channel starts a block on the one shared MAC: 2*BANDS*TAPS
// filter products, then BANDS bands of 2*BANDS products each, all through the single MAC and
// memory port; no request is taken until the last band has gone to the result channel, and
// a result channel that holds off stalls the block. Synchronous reset; afterwards a clearing
// pass zeroes all CHANNELS*2*BANDS*TAPS entries of the sample memory, no request taken.
module polyphase_analysis_filterbank_core #(
  parameter int CHANNELS = pafb_pkg::DEF_CHANNELS,
  parameter int BANDS    = pafb_pkg::DEF_BANDS,
  parameter int TAPS     = pafb_pkg::DEF_TAPS
) (
  input  wire          clk,
  input  wire          rst_n,
  pafb_in_if.sink      in_req,
  pafb_out_if.source   out_res
);

  localparam int PHASES    = 2 * BANDS;
  localparam int BUF_LEN   = PHASES * TAPS;
  localparam int PH_W      = $clog2(PHASES);
  localparam int TAP_W     = $clog2(TAPS);
  localparam int BUF_W     = PH_W + TAP_W;
  localparam int BAND_W    = $clog2(BANDS);
  localparam int ANG_W     = $clog2(4 * BANDS);
  localparam int ROM_STEP  = 64 / BANDS;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SA_DEPTH  = CHANNELS * BUF_LEN;
  localparam int SA_W      = $clog2(SA_DEPTH);
  localparam int FC_W      = $clog2(BANDS + 1);
  localparam int FIR_W     = pafb_pkg::SAMPLE_W + pafb_pkg::COEF_W + TAP_W - pafb_pkg::FRAC_SH;
  localparam int ACC_W     = FIR_W + pafb_pkg::COS_W + PH_W;
  localparam int V_W       = ACC_W - pafb_pkg::FRAC_SH;

  localparam logic signed [V_W-1:0] SAT_MAX = {{(V_W - 32){1'b0}}, 32'h7fffffff};
  localparam logic signed [V_W-1:0] SAT_MIN = {{(V_W - 32){1'b1}}, 32'h80000000};

  // sequencer states
  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_A_ISSUE = 3'd2;
  localparam logic [2:0] S_A_DRAIN = 3'd3;
  localparam logic [2:0] S_B_ISSUE = 3'd4;
  localparam logic [2:0] S_B_WAIT  = 3'd5;
  localparam logic [2:0] S_B_EMIT  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [SA_W-1:0]   clr_r, clr_nxt;
  logic [BUF_W-1:0]  cnt_r, cnt_nxt;
  logic [BAND_W-1:0] band_r, band_nxt;
  logic [ANG_W-1:0]  ang_r, ang_nxt;
  logic [ANG_W-1:0]  base_r, base_nxt;
  logic [ANG_W-1:0]  step_r, step_nxt;
  logic [PH_W-1:0]   fir_cnt_r;

  logic [BUF_W-1:0]  wp_r   [CHANNELS];
  logic [FC_W-1:0]   fill_r [CHANNELS];
  logic [CH_W-1:0]   ch_r;
  logic [BUF_W-1:0]  pos_r;

  logic signed [pafb_pkg::SAMPLE_W-1:0] smem [SA_DEPTH];
  logic signed [pafb_pkg::COEF_W-1:0]   wmem [BUF_LEN];
  logic signed [FIR_W-1:0]              fmem [PHASES];

  logic signed [pafb_pkg::SAMPLE_W-1:0] samp_rd_r;
  logic signed [pafb_pkg::COEF_W-1:0]   win_rd_r;
  logic signed [FIR_W-1:0]              fir_rd_r;
  logic signed [pafb_pkg::COS_W-1:0]    cos_r;
  pafb_pkg::mac_ctl_t                   ctl0, ctl1_r;
  logic                                 sel1_r;

  logic                      out_valid_r;
  logic signed [31:0]        out_value_r;
  logic [BAND_W-1:0]         out_band_r;
  logic [CH_W-1:0]           out_ch_r;
  logic                      out_last_r;
  logic                      out_sat_r;

  logic                      in_ready, in_acc, smp_acc, blk_start, out_free, fir_phase;
  logic [CH_W-1:0]           ch_idx;
  logic [BUF_W-1:0]          wp_inc;
  logic [TAP_W-1:0]          tap_j;
  logic [PH_W-1:0]           tap_ph;
  logic [BUF_W-1:0]          s_off;
  logic [7:0]                ang8;
  logic signed [FIR_W-1:0]   mac_a;
  logic signed [pafb_pkg::COEF_W-1:0] mac_b;
  logic signed [ACC_W-1:0]   mac_acc;
  logic                      mac_done;
  logic signed [V_W-1:0]     band_v;

  // request decode
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_req.valid && in_ready;
  assign ch_idx    = CH_W'(in_req.channel);
  assign smp_acc   = in_acc && (in_req.cmd == pafb_pkg::CMD_SAMPLE)
                     && (int'(in_req.channel) < CHANNELS);
  assign wp_inc    = wp_r[ch_idx] + BUF_W'(1);
  assign blk_start = smp_acc && (fill_r[ch_idx] == FC_W'(BANDS - 1));
  assign out_free  = !out_valid_r || out_res.ready;
  assign fir_phase = (state_r == S_A_ISSUE) || (state_r == S_A_DRAIN);

  // issue-side addressing
  assign tap_j  = cnt_r[TAP_W-1:0];
  assign tap_ph = cnt_r[BUF_W-1:TAP_W];
  assign s_off  = {tap_j, tap_ph};
  assign ang8   = 8'(int'(ang_r) * ROM_STEP);

  always_comb begin
    ctl0 = '0;
    if (state_r == S_A_ISSUE) begin
      ctl0.valid = 1'b1;
      ctl0.neg   = tap_j[0];
      ctl0.first = (tap_j == '0);
      ctl0.last  = (tap_j == TAP_W'(TAPS - 1));
    end else if (state_r == S_B_ISSUE) begin
      ctl0.valid = 1'b1;
      ctl0.first = (cnt_r[PH_W-1:0] == '0);
      ctl0.last  = (cnt_r[PH_W-1:0] == PH_W'(PHASES - 1));
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    band_nxt  = band_r;
    ang_nxt   = ang_r;
    base_nxt  = base_r;
    step_nxt  = step_r;
    case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + SA_W'(1);
        if (clr_r == SA_W'(SA_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (blk_start) begin
          state_nxt = S_A_ISSUE;
          cnt_nxt   = '0;
        end
      end
      S_A_ISSUE: begin
        cnt_nxt = cnt_r + BUF_W'(1);
        if (cnt_r == BUF_W'(BUF_LEN - 1)) begin
          state_nxt = S_A_DRAIN;
        end
      end
      S_A_DRAIN: begin
        if (mac_done && fir_cnt_r == PH_W'(PHASES - 1)) begin
          state_nxt = S_B_ISSUE;
          cnt_nxt   = '0;
          band_nxt  = '0;
          base_nxt  = ANG_W'(7 * BANDS / 2);
          ang_nxt   = ANG_W'(7 * BANDS / 2);
          step_nxt  = ANG_W'(1);
        end
      end
      S_B_ISSUE: begin
        cnt_nxt = cnt_r + BUF_W'(1);
        ang_nxt = ang_r + step_r;
        if (cnt_r[PH_W-1:0] == PH_W'(PHASES - 1)) begin
          state_nxt = S_B_WAIT;
        end
      end
      S_B_WAIT: begin
        if (mac_done) begin
          state_nxt = S_B_EMIT;
        end
      end
      S_B_EMIT: begin
        if (out_free) begin
          cnt_nxt = '0;
          if (band_r == BAND_W'(BANDS - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_B_ISSUE;
            band_nxt  = band_r + BAND_W'(1);
            base_nxt  = base_r + ANG_W'(7 * BANDS);
            ang_nxt   = base_r + ANG_W'(7 * BANDS);
            step_nxt  = step_r + ANG_W'(2);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      cnt_r     <= '0;
      band_r    <= '0;
      ang_r     <= '0;
      base_r    <= '0;
      step_r    <= '0;
      fir_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      band_r  <= band_nxt;
      ang_r   <= ang_nxt;
      base_r  <= base_nxt;
      step_r  <= step_nxt;
      if (mac_done && fir_phase) begin
        fir_cnt_r <= fir_cnt_r + PH_W'(1);
      end
    end
  end

  // per-channel ring position and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wp_r[c]   <= '0;
        fill_r[c] <= '0;
      end
    end else if (smp_acc) begin
      wp_r[ch_idx]   <= wp_inc;
      fill_r[ch_idx] <= blk_start ? '0 : fill_r[ch_idx] + FC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (blk_start) begin
      ch_r  <= ch_idx;
      pos_r <= wp_inc;
    end
  end

  // sample memory: clearing pass, sample writes, one read port
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      smem[clr_r] <= '0;
    end else if (smp_acc) begin
      smem[SA_W'({ch_idx, wp_r[ch_idx]})] <= in_req.sample;
    end
    samp_rd_r <= smem[SA_W'({ch_r, pos_r - s_off})];
  end

  // window memory
  always_ff @(posedge clk) begin
    if (in_acc && in_req.cmd == pafb_pkg::CMD_COEF && int'(in_req.coef_index) < BUF_LEN) begin
      wmem[BUF_W'(in_req.coef_index)] <= in_req.coef_value;
    end
    win_rd_r <= wmem[s_off];
  end

  // polyphase results
  always_ff @(posedge clk) begin
    if (mac_done && fir_phase) begin
      fmem[fir_cnt_r] <= FIR_W'(mac_acc >>> pafb_pkg::FRAC_SH);
    end
    fir_rd_r <= fmem[cnt_r[PH_W-1:0]];
  end

  // cosine weight and tags aligned with the memory reads
  always_ff @(posedge clk) begin
    cos_r  <= pafb_pkg::cos_lookup(ang8);
    sel1_r <= (state_r == S_B_ISSUE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r <= ctl0;
    end
  end

  assign mac_a = sel1_r ? fir_rd_r : FIR_W'(samp_rd_r);
  assign mac_b = sel1_r ? cos_r : win_rd_r;

  pafb_mac #(
    .A_W   (FIR_W),
    .B_W   (pafb_pkg::COEF_W),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl1_r),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .acc   (mac_acc),
    .done  (mac_done)
  );

  // result register with saturation
  assign band_v = V_W'(mac_acc >>> pafb_pkg::FRAC_SH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_B_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_B_EMIT && out_free) begin
      out_band_r <= band_r;
      out_ch_r   <= ch_r;
      out_last_r <= (band_r == BAND_W'(BANDS - 1));
      if (band_v > SAT_MAX) begin
        out_value_r <= 32'sh7fffffff;
        out_sat_r   <= 1'b1;
      end else if (band_v < SAT_MIN) begin
        out_value_r <= 32'sh80000000;
        out_sat_r   <= 1'b1;
      end else begin
        out_value_r <= 32'(band_v);
        out_sat_r   <= 1'b0;
      end
    end
  end

  assign in_req.ready          = in_ready;
  assign out_res.valid         = out_valid_r;
  assign out_res.subband_value = out_value_r;
  assign out_res.band_index    = pafb_pkg::BAND_FIELD_W'(out_band_r);
  assign out_res.channel_out   = pafb_pkg::CH_FIELD_W'(out_ch_r);
  assign out_res.last          = out_last_r;
  assign out_res.saturated     = out_sat_r;

`ifndef SYNTHESIS
  a_blk_start: assert property (@(posedge clk) disable iff (!rst_n)
    blk_start |=> state_r == S_A_ISSUE)
    else $error("block start did not enter the filter pass");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r != S_IDLE && state_r != S_CLEAR))
    else $error("MAC completion outside a block");
  a_last_band: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> out_band_r == BAND_W'(BANDS - 1))
    else $error("last flag on a band other than the final one");
`endif

endmodule

`default_nettype wire
